[src/tksd_pkg.sv]
// Shared types and constants for the terminal key sequence decoder.
// Depends on nothing; used by tksd_decode and terminal_key_sequence_decoder.
`timescale 1ns / 1ps

package tksd_pkg;

  localparam int CODE_W = 21;
  localparam int KEY_W  = 5;

  // One input item: a console byte, or an idle marker
  typedef struct packed {
    logic       idle;
    logic [7:0] data;
  } item_t;

  // One key event
  typedef struct packed {
    logic              ctrl;
    logic              shift;
    logic [CODE_W-1:0] code;
    logic              kind;
  } result_t;

  // Event kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_CTRL = 1'b1;

  // Control key codes
  localparam logic [KEY_W-1:0] KEY_ESCAPE = 5'd0;
  localparam logic [KEY_W-1:0] KEY_UP     = 5'd1;
  localparam logic [KEY_W-1:0] KEY_DOWN   = 5'd2;
  localparam logic [KEY_W-1:0] KEY_RIGHT  = 5'd3;
  localparam logic [KEY_W-1:0] KEY_LEFT   = 5'd4;
  localparam logic [KEY_W-1:0] KEY_END    = 5'd5;
  localparam logic [KEY_W-1:0] KEY_HOME   = 5'd6;
  localparam logic [KEY_W-1:0] KEY_F1     = 5'd7;
  localparam logic [KEY_W-1:0] KEY_F6     = 5'd12;
  localparam logic [KEY_W-1:0] KEY_F9     = 5'd15;
  localparam logic [KEY_W-1:0] KEY_INSERT = 5'd19;
  localparam logic [KEY_W-1:0] KEY_DELETE = 5'd20;
  localparam logic [KEY_W-1:0] KEY_PGUP   = 5'd21;
  localparam logic [KEY_W-1:0] KEY_PGDN   = 5'd22;
  localparam logic [KEY_W-1:0] KEY_PASTE0 = 5'd23;
  localparam logic [KEY_W-1:0] KEY_PASTE1 = 5'd24;

  // Byte values of interest
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B; // '['
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_LB    = 8'h62; // 'b'
  localparam logic [7:0] CH_LF    = 8'h66; // 'f'
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_CARET = 8'h5E;

  // UTF-8 lead byte masks and patterns
  localparam logic [7:0] UTF_MASK1 = 8'h80;
  localparam logic [7:0] UTF_MASK2 = 8'hE0;
  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_MASK3 = 8'hF0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_MASK4 = 8'hF8;
  localparam logic [7:0] UTF_LEAD4 = 8'hF0;

endpackage

[src/tksd_decode.sv]
// Sequence parser: phase state, held bytes, UTF-8 accumulator and the result register.
// Depends on tksd_pkg.
`timescale 1ns / 1ps

module tksd_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             itm_vld,   // item waiting in the input register
  input  tksd_pkg::item_t  itm,
  output logic             itm_take,  // item consumed this cycle
  output logic             res_vld,
  output tksd_pkg::result_t res,
  input  logic             res_take
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ESC, PH_CSI, PH_SS3, PH_C1A, PH_C1B, PH_C1SEMI,
    PH_C2A, PH_C2B, PH_C2C, PH_CNUM, PH_C3X, PH_UTF8
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [7:0]                     h0_r, h0_nxt, h1_r, h1_nxt, h2_r, h2_nxt;
  logic [tksd_pkg::CODE_W-1:0]    acc_r, acc_nxt;
  logic [1:0]                     rem_r, rem_nxt;
  logic                           res_vld_r, res_vld_nxt;
  tksd_pkg::result_t              res_r, res_nxt;

  logic                           emit;
  logic                           ekind, eshift, ectrl;
  logic [tksd_pkg::CODE_W-1:0]    ecode;
  logic [tksd_pkg::KEY_W-1:0]     key;
  logic [7:0]                     b;
  logic                           term;  // '~' or '^'
  logic [tksd_pkg::CODE_W-1:0]    acc_sh;
  logic [1:0]                     rem_dec;

  assign itm_take = itm_vld && (!res_vld_r || res_take);
  assign res_vld  = res_vld_r;
  assign res      = res_r;

  assign b       = itm.data;
  assign term    = (b == tksd_pkg::CH_TILDE) || (b == tksd_pkg::CH_CARET);
  assign acc_sh  = {acc_r[tksd_pkg::CODE_W-7:0], b[5:0]};
  assign rem_dec = rem_r - 2'd1;

  // Next-state and event decode for one item
  always_comb begin
    phase_nxt = phase_r;
    h0_nxt    = h0_r;
    h1_nxt    = h1_r;
    h2_nxt    = h2_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    emit      = 1'b0;
    ekind     = tksd_pkg::KIND_CTRL;
    key       = tksd_pkg::KEY_ESCAPE;
    ecode     = '0;
    eshift    = 1'b0;
    ectrl     = 1'b0;

    if (itm.idle) begin
      // idle ends whatever is open; only a lone ESC gives a key
      phase_nxt = PH_IDLE;
      rem_nxt   = 2'd0;
      emit      = (phase_r == PH_ESC);
      key       = tksd_pkg::KEY_ESCAPE;
    end else begin
      // default outcome: sequence closed (emit or drop)
      phase_nxt = PH_IDLE;
      case (phase_r)
        PH_IDLE: begin
          if (b == tksd_pkg::CH_ESC) begin
            phase_nxt = PH_ESC;
          end else if ((b & tksd_pkg::UTF_MASK1) == 8'h00) begin
            emit  = 1'b1;
            ekind = tksd_pkg::KIND_CHAR;
          end else if ((b & tksd_pkg::UTF_MASK2) == tksd_pkg::UTF_LEAD2) begin
            acc_nxt   = tksd_pkg::CODE_W'(b[4:0]);
            rem_nxt   = 2'd1;
            phase_nxt = PH_UTF8;
          end else if ((b & tksd_pkg::UTF_MASK3) == tksd_pkg::UTF_LEAD3) begin
            acc_nxt   = tksd_pkg::CODE_W'(b[3:0]);
            rem_nxt   = 2'd2;
            phase_nxt = PH_UTF8;
          end else if ((b & tksd_pkg::UTF_MASK4) == tksd_pkg::UTF_LEAD4) begin
            acc_nxt   = tksd_pkg::CODE_W'(b[2:0]);
            rem_nxt   = 2'd3;
            phase_nxt = PH_UTF8;
          end else begin
            rem_nxt = 2'd0;
          end
        end
        PH_UTF8: begin
          acc_nxt = acc_sh;
          rem_nxt = rem_dec;
          if (rem_dec == 2'd0) begin
            emit  = 1'b1;
            ekind = tksd_pkg::KIND_CHAR;
          end else begin
            phase_nxt = PH_UTF8;
          end
        end
        PH_ESC: begin
          if (b == tksd_pkg::CH_LBRK) begin
            phase_nxt = PH_CSI;
          end else if (b == tksd_pkg::CH_O) begin
            phase_nxt = PH_SS3;
          end else if (b == tksd_pkg::CH_LB) begin
            emit = 1'b1; key = tksd_pkg::KEY_LEFT; ectrl = 1'b1;
          end else if (b == tksd_pkg::CH_LF) begin
            emit = 1'b1; key = tksd_pkg::KEY_RIGHT; ectrl = 1'b1;
          end else begin
            rem_nxt = 2'd0;
          end
        end
        PH_SS3: begin
          if (b >= tksd_pkg::CH_P && b <= tksd_pkg::CH_S) begin
            emit = 1'b1;
            key  = tksd_pkg::KEY_F1 + tksd_pkg::KEY_W'(b[1:0]);
          end else begin
            rem_nxt = 2'd0;
          end
        end
        PH_CSI: begin
          if (b == tksd_pkg::CH_A) begin
            emit = 1'b1; key = tksd_pkg::KEY_UP;
          end else if (b == tksd_pkg::CH_B) begin
            emit = 1'b1; key = tksd_pkg::KEY_DOWN;
          end else if (b == tksd_pkg::CH_C) begin
            emit = 1'b1; key = tksd_pkg::KEY_RIGHT;
          end else if (b == tksd_pkg::CH_D) begin
            emit = 1'b1; key = tksd_pkg::KEY_LEFT;
          end else if (b == tksd_pkg::CH_F) begin
            emit = 1'b1; key = tksd_pkg::KEY_END;
          end else if (b == tksd_pkg::CH_H) begin
            emit = 1'b1; key = tksd_pkg::KEY_HOME;
          end else if (b == tksd_pkg::CH_1) begin
            phase_nxt = PH_C1A;
          end else if (b == tksd_pkg::CH_2) begin
            phase_nxt = PH_C2A;
          end else if (b >= tksd_pkg::CH_3 && b <= tksd_pkg::CH_8) begin
            h0_nxt    = b;
            phase_nxt = PH_CNUM;
          end else begin
            rem_nxt = 2'd0;
          end
        end
        PH_C1A: begin
          h1_nxt    = b;
          phase_nxt = PH_C1B;
        end
        PH_C1B: begin
          if (term) begin
            ectrl = (b == tksd_pkg::CH_CARET);
            if (h1_r >= tksd_pkg::CH_1 && h1_r <= tksd_pkg::CH_5) begin
              emit = 1'b1;
              key  = tksd_pkg::KEY_F1 + tksd_pkg::KEY_W'(h1_r - tksd_pkg::CH_1);
            end else if (h1_r >= tksd_pkg::CH_7 && h1_r <= tksd_pkg::CH_9) begin
              emit = 1'b1;
              key  = tksd_pkg::KEY_F6 + tksd_pkg::KEY_W'(h1_r - tksd_pkg::CH_7);
            end else begin
              rem_nxt = 2'd0;
            end
          end else if (h1_r == tksd_pkg::CH_SEMI && b == tksd_pkg::CH_2) begin
            phase_nxt = PH_C1SEMI;
          end else begin
            rem_nxt = 2'd0;
          end
        end
        PH_C1SEMI: begin
          eshift = 1'b1;
          if (b == tksd_pkg::CH_C) begin
            emit = 1'b1; key = tksd_pkg::KEY_RIGHT;
          end else if (b == tksd_pkg::CH_D) begin
            emit = 1'b1; key = tksd_pkg::KEY_LEFT;
          end else begin
            rem_nxt = 2'd0;
          end
        end
        PH_C2A: begin
          if (b == tksd_pkg::CH_TILDE) begin
            emit = 1'b1; key = tksd_pkg::KEY_INSERT;
          end else begin
            h1_nxt    = b;
            phase_nxt = PH_C2B;
          end
        end
        PH_C2B: begin
          if (term) begin
            ectrl = (b == tksd_pkg::CH_CARET);
            emit  = 1'b1;
            // F9-F12 plain, F5-F8 as the shifted group
            case (h1_r)
              tksd_pkg::CH_0: key = tksd_pkg::KEY_F1 + 5'd8;
              tksd_pkg::CH_1: key = tksd_pkg::KEY_F1 + 5'd9;
              tksd_pkg::CH_3: key = tksd_pkg::KEY_F1 + 5'd10;
              tksd_pkg::CH_4: key = tksd_pkg::KEY_F1 + 5'd11;
              tksd_pkg::CH_5: begin key = tksd_pkg::KEY_F1 + 5'd4; eshift = 1'b1; end
              tksd_pkg::CH_6: begin key = tksd_pkg::KEY_F1 + 5'd5; eshift = 1'b1; end
              tksd_pkg::CH_8: begin key = tksd_pkg::KEY_F1 + 5'd6; eshift = 1'b1; end
              tksd_pkg::CH_9: begin key = tksd_pkg::KEY_F1 + 5'd7; eshift = 1'b1; end
              default: begin
                emit    = 1'b0;
                rem_nxt = 2'd0;
              end
            endcase
          end else begin
            h2_nxt    = b;
            phase_nxt = PH_C2C;
          end
        end
        PH_C2C: begin
          // bracketed paste: CSI 2 0 0 ~ / CSI 2 0 1 ~
          if (b == tksd_pkg::CH_TILDE && h1_r == tksd_pkg::CH_0 &&
              h2_r == tksd_pkg::CH_0) begin
            emit = 1'b1; key = tksd_pkg::KEY_PASTE0;
          end else if (b == tksd_pkg::CH_TILDE && h1_r == tksd_pkg::CH_0 &&
                       h2_r == tksd_pkg::CH_1) begin
            emit = 1'b1; key = tksd_pkg::KEY_PASTE1;
          end else begin
            rem_nxt = 2'd0;
          end
        end
        PH_CNUM: begin
          if (b == tksd_pkg::CH_TILDE) begin
            emit = 1'b1;
            case (h0_r)
              tksd_pkg::CH_3: key = tksd_pkg::KEY_DELETE;
              tksd_pkg::CH_5: key = tksd_pkg::KEY_PGUP;
              tksd_pkg::CH_6: key = tksd_pkg::KEY_PGDN;
              tksd_pkg::CH_7: key = tksd_pkg::KEY_HOME;
              default:        key = tksd_pkg::KEY_END;
            endcase
          end else if (h0_r == tksd_pkg::CH_3) begin
            h1_nxt    = b;
            phase_nxt = PH_C3X;
          end else begin
            rem_nxt = 2'd0;
          end
        end
        PH_C3X: begin
          // shifted F9-F12 as CSI 3 x ~
          if (b == tksd_pkg::CH_TILDE && h1_r >= tksd_pkg::CH_1 &&
              h1_r <= tksd_pkg::CH_4) begin
            emit   = 1'b1;
            eshift = 1'b1;
            key    = tksd_pkg::KEY_F9 + tksd_pkg::KEY_W'(h1_r - tksd_pkg::CH_1);
          end else begin
            rem_nxt = 2'd0;
          end
        end
        default: begin
          rem_nxt = 2'd0;
        end
      endcase
    end

    // event code: byte or code point for characters, key number otherwise
    if (ekind == tksd_pkg::KIND_CHAR) begin
      ecode  = (phase_r == PH_UTF8) ? acc_sh : tksd_pkg::CODE_W'(b);
      eshift = 1'b0;
      ectrl  = 1'b0;
    end else begin
      ecode = tksd_pkg::CODE_W'(key);
    end
  end

  // Result register
  always_comb begin
    res_vld_nxt = res_vld_r && !res_take;
    res_nxt     = res_r;
    if (itm_take && emit) begin
      res_vld_nxt   = 1'b1;
      res_nxt.kind  = ekind;
      res_nxt.code  = ecode;
      res_nxt.shift = eshift;
      res_nxt.ctrl  = ectrl;
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      acc_r     <= '0;
      rem_r     <= 2'd0;
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= res_vld_nxt;
      if (itm_take) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        rem_r   <= rem_nxt;
      end
    end
  end

  // Held bytes and result payload carry no reset
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (itm_take) begin
      h0_r <= h0_nxt;
      h1_r <= h1_nxt;
      h2_r <= h2_nxt;
    end
  end

endmodule

[src/terminal_key_sequence_decoder.sv]
// Top level of the terminal key sequence decoder: input register and stream ports.
// Depends on tksd_pkg and tksd_decode.
`timescale 1ns / 1ps

// Decodes console bytes into key events, one byte per clock. A byte (or an
// idle marker, in_tuser high) is taken into an input register, then parsed
// against the open escape or UTF-8 sequence in a single step that loads the
// result register; an item that completes a key gives one event, others give
// none. out_tvalid rises once the item that completes a key has passed from
// the input register into the result register; a waiting event stalls that
// step. A new item is accepted every cycle as long as the result side keeps
// taking events: the only limit is the single result register. While an event
// waits with out_tready low, no item is parsed, the input register holds and
// in_tready drops once it is full; in_tready follows out_tready in the same
// cycle. Both event kinds carry their code (code point or key number) in
// out_tdata; out_tuser holds the event kind and the shift/control flags.
module terminal_key_sequence_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic [0:0]  in_tuser,   // [0] byte_idle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] key_code, [23:21] zero
  output logic [2:0]  out_tuser   // [0] event_kind, [1] shift_flag, [2] control_flag
);

  logic              itm_vld_r, itm_vld_nxt;
  tksd_pkg::item_t   itm_r, itm_nxt;
  logic              itm_take;
  logic              in_acc;
  tksd_pkg::result_t res;

  assign in_tready = !itm_vld_r || itm_take;
  assign in_acc    = in_tvalid && in_tready;

  // Input register
  always_comb begin
    itm_vld_nxt = itm_vld_r && !itm_take;
    itm_nxt     = itm_r;
    if (in_acc) begin
      itm_vld_nxt  = 1'b1;
      itm_nxt.data = in_tdata;
      itm_nxt.idle = in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itm_vld_r <= 1'b0;
    end else begin
      itm_vld_r <= itm_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    itm_r <= itm_nxt;
  end

  tksd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .itm_vld  (itm_vld_r),
    .itm      (itm_r),
    .itm_take (itm_take),
    .res_vld  (out_tvalid),
    .res      (res),
    .res_take (out_tready)
  );

  // Pack the result item
  assign out_tdata = {3'b000, res.code};
  assign out_tuser = {res.ctrl, res.shift, res.kind};

endmodule

[sim/tb_terminal_key_sequence_decoder.sv]
// Testbench for terminal_key_sequence_decoder: drives console bytes and idle markers,
// predicts the key events and checks every event field. Depends on tksd_pkg and the RTL.
`timescale 1ns / 1ps

module tb_terminal_key_sequence_decoder;

  localparam int          RANDOM_ITEMS = 1500;
  localparam int          HOLD_START   = 1000;  // receiver cycle where the long stall begins
  localparam int          HOLD_LEN     = 300;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          DRAIN_LIMIT  = 20000;
  localparam longint      TIMEOUT_NS   = 5_000_000;
  localparam logic [47:0] CSI_FINALS   = {tksd_pkg::CH_H, tksd_pkg::CH_F, tksd_pkg::CH_D,
                                          tksd_pkg::CH_C, tksd_pkg::CH_B, tksd_pkg::CH_A};

  // Parser position inside an escape or UTF-8 sequence
  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_ESC, SEQ_CSI, SEQ_SS3, SEQ_C1A, SEQ_C1B, SEQ_C1SEMI,
    SEQ_C2A, SEQ_C2B, SEQ_C2C, SEQ_CNUM, SEQ_C3X, SEQ_UTF8
  } seq_phase_t;

  // Predicts key events from accepted items and checks the events that come out
  class key_event_scoreboard;
    seq_phase_t                  phase;
    logic [7:0]                  held [3];
    logic [tksd_pkg::CODE_W-1:0] cp_accum;
    logic [1:0]                  cp_left;
    tksd_pkg::result_t           pending_events[$];
    int                          errors;

    function new();
      phase    = SEQ_IDLE;
      held     = '{8'h00, 8'h00, 8'h00};
      cp_accum = '0;
      cp_left  = '0;
      errors   = 0;
    endfunction

    function tksd_pkg::result_t ctrl_event(logic [tksd_pkg::KEY_W-1:0] key, logic sh,
                                           logic ct);
      tksd_pkg::result_t ev;
      ev.kind  = tksd_pkg::KIND_CTRL;
      ev.code  = tksd_pkg::CODE_W'(key);
      ev.shift = sh;
      ev.ctrl  = ct;
      return ev;
    endfunction

    function tksd_pkg::result_t char_event(logic [tksd_pkg::CODE_W-1:0] code);
      tksd_pkg::result_t ev;
      ev.kind  = tksd_pkg::KIND_CHAR;
      ev.code  = code;
      ev.shift = 1'b0;
      ev.ctrl  = 1'b0;
      return ev;
    endfunction

    function void push_ctrl(logic [tksd_pkg::KEY_W-1:0] key, logic sh, logic ct);
      pending_events.push_back(ctrl_event(key, sh, ct));
    endfunction

    // Advance the parser by one accepted item; any event goes on the pending queue.
    // The phase falls back to idle unless a case below keeps a sequence open.
    function void note_item(logic [7:0] b, logic idl);
      seq_phase_t cur;
      logic       ct;
      cur   = phase;
      phase = SEQ_IDLE;
      ct    = (b == tksd_pkg::CH_CARET);
      if (idl) begin
        cp_left = '0;
        if (cur == SEQ_ESC) push_ctrl(tksd_pkg::KEY_ESCAPE, 1'b0, 1'b0);
        return;
      end
      case (cur)
        SEQ_IDLE: begin
          if (b == tksd_pkg::CH_ESC) begin
            phase = SEQ_ESC;
          end else if ((b & tksd_pkg::UTF_MASK1) == 8'h00) begin
            pending_events.push_back(char_event(tksd_pkg::CODE_W'(b)));
          end else if ((b & tksd_pkg::UTF_MASK2) == tksd_pkg::UTF_LEAD2) begin
            cp_accum = tksd_pkg::CODE_W'(b[4:0]);
            cp_left  = 2'd1;
            phase    = SEQ_UTF8;
          end else if ((b & tksd_pkg::UTF_MASK3) == tksd_pkg::UTF_LEAD3) begin
            cp_accum = tksd_pkg::CODE_W'(b[3:0]);
            cp_left  = 2'd2;
            phase    = SEQ_UTF8;
          end else if ((b & tksd_pkg::UTF_MASK4) == tksd_pkg::UTF_LEAD4) begin
            cp_accum = tksd_pkg::CODE_W'(b[2:0]);
            cp_left  = 2'd3;
            phase    = SEQ_UTF8;
          end
        end
        SEQ_UTF8: begin
          // continuation bits are taken without checking the top two bits
          cp_accum = {cp_accum[tksd_pkg::CODE_W-7:0], b[5:0]};
          cp_left  = cp_left - 2'd1;
          if (cp_left == 2'd0) pending_events.push_back(char_event(cp_accum));
          else phase = SEQ_UTF8;
        end
        SEQ_ESC: begin
          if (b == tksd_pkg::CH_LBRK) phase = SEQ_CSI;
          else if (b == tksd_pkg::CH_O) phase = SEQ_SS3;
          else if (b == tksd_pkg::CH_LB) push_ctrl(tksd_pkg::KEY_LEFT, 1'b0, 1'b1);
          else if (b == tksd_pkg::CH_LF) push_ctrl(tksd_pkg::KEY_RIGHT, 1'b0, 1'b1);
        end
        SEQ_SS3: begin
          if (b >= tksd_pkg::CH_P && b <= tksd_pkg::CH_S)
            push_ctrl(tksd_pkg::KEY_F1 + tksd_pkg::KEY_W'(b - tksd_pkg::CH_P), 1'b0, 1'b0);
        end
        SEQ_CSI: begin
          case (b)
            tksd_pkg::CH_A: push_ctrl(tksd_pkg::KEY_UP, 1'b0, 1'b0);
            tksd_pkg::CH_B: push_ctrl(tksd_pkg::KEY_DOWN, 1'b0, 1'b0);
            tksd_pkg::CH_C: push_ctrl(tksd_pkg::KEY_RIGHT, 1'b0, 1'b0);
            tksd_pkg::CH_D: push_ctrl(tksd_pkg::KEY_LEFT, 1'b0, 1'b0);
            tksd_pkg::CH_F: push_ctrl(tksd_pkg::KEY_END, 1'b0, 1'b0);
            tksd_pkg::CH_H: push_ctrl(tksd_pkg::KEY_HOME, 1'b0, 1'b0);
            tksd_pkg::CH_1: phase = SEQ_C1A;
            tksd_pkg::CH_2: phase = SEQ_C2A;
            default: begin
              if (b >= tksd_pkg::CH_3 && b <= tksd_pkg::CH_8) begin
                held[0] = b;
                phase   = SEQ_CNUM;
              end
            end
          endcase
        end
        SEQ_C1A: begin
          held[1] = b;
          phase   = SEQ_C1B;
        end
        SEQ_C1B: begin
          if (b == tksd_pkg::CH_TILDE || b == tksd_pkg::CH_CARET) begin
            if (held[1] >= tksd_pkg::CH_1 && held[1] <= tksd_pkg::CH_5)
              push_ctrl(tksd_pkg::KEY_F1 + tksd_pkg::KEY_W'(held[1] - tksd_pkg::CH_1),
                        1'b0, ct);
            else if (held[1] >= tksd_pkg::CH_7 && held[1] <= tksd_pkg::CH_9)
              push_ctrl(tksd_pkg::KEY_F6 + tksd_pkg::KEY_W'(held[1] - tksd_pkg::CH_7),
                        1'b0, ct);
          end else if (held[1] == tksd_pkg::CH_SEMI && b == tksd_pkg::CH_2) begin
            phase = SEQ_C1SEMI;
          end
        end
        SEQ_C1SEMI: begin
          if (b == tksd_pkg::CH_C) push_ctrl(tksd_pkg::KEY_RIGHT, 1'b1, 1'b0);
          else if (b == tksd_pkg::CH_D) push_ctrl(tksd_pkg::KEY_LEFT, 1'b1, 1'b0);
        end
        SEQ_C2A: begin
          if (b == tksd_pkg::CH_TILDE) begin
            push_ctrl(tksd_pkg::KEY_INSERT, 1'b0, 1'b0);
          end else begin
            held[1] = b;
            phase   = SEQ_C2B;
          end
        end
        SEQ_C2B: begin
          if (b == tksd_pkg::CH_TILDE || b == tksd_pkg::CH_CARET) begin
            // 20, 21, 23, 24 are F9..F12; 25, 26, 28, 29 the shifted F5..F8 group
            case (held[1])
              tksd_pkg::CH_0: push_ctrl(tksd_pkg::KEY_F9, 1'b0, ct);
              tksd_pkg::CH_1: push_ctrl(tksd_pkg::KEY_F9 + 5'd1, 1'b0, ct);
              tksd_pkg::CH_3: push_ctrl(tksd_pkg::KEY_F9 + 5'd2, 1'b0, ct);
              tksd_pkg::CH_4: push_ctrl(tksd_pkg::KEY_F9 + 5'd3, 1'b0, ct);
              tksd_pkg::CH_5: push_ctrl(tksd_pkg::KEY_F1 + 5'd4, 1'b1, ct);
              tksd_pkg::CH_6: push_ctrl(tksd_pkg::KEY_F6, 1'b1, ct);
              tksd_pkg::CH_8: push_ctrl(tksd_pkg::KEY_F6 + 5'd1, 1'b1, ct);
              tksd_pkg::CH_9: push_ctrl(tksd_pkg::KEY_F6 + 5'd2, 1'b1, ct);
              default: ;
            endcase
          end else begin
            held[2] = b;
            phase   = SEQ_C2C;
          end
        end
        SEQ_C2C: begin
          if (b == tksd_pkg::CH_TILDE && held[1] == tksd_pkg::CH_0) begin
            if (held[2] == tksd_pkg::CH_0) push_ctrl(tksd_pkg::KEY_PASTE0, 1'b0, 1'b0);
            else if (held[2] == tksd_pkg::CH_1)
              push_ctrl(tksd_pkg::KEY_PASTE1, 1'b0, 1'b0);
          end
        end
        SEQ_CNUM: begin
          if (b == tksd_pkg::CH_TILDE) begin
            case (held[0])
              tksd_pkg::CH_3: push_ctrl(tksd_pkg::KEY_DELETE, 1'b0, 1'b0);
              tksd_pkg::CH_5: push_ctrl(tksd_pkg::KEY_PGUP, 1'b0, 1'b0);
              tksd_pkg::CH_6: push_ctrl(tksd_pkg::KEY_PGDN, 1'b0, 1'b0);
              tksd_pkg::CH_7: push_ctrl(tksd_pkg::KEY_HOME, 1'b0, 1'b0);
              default: push_ctrl(tksd_pkg::KEY_END, 1'b0, 1'b0);
            endcase
          end else if (held[0] == tksd_pkg::CH_3) begin
            held[1] = b;
            phase   = SEQ_C3X;
          end
        end
        SEQ_C3X: begin
          if (b == tksd_pkg::CH_TILDE && held[1] >= tksd_pkg::CH_1 &&
              held[1] <= tksd_pkg::CH_4)
            push_ctrl(tksd_pkg::KEY_F9 + tksd_pkg::KEY_W'(held[1] - tksd_pkg::CH_1),
                      1'b1, 1'b0);
        end
        default: ;
      endcase
    endfunction

    // Compare one output event with the oldest prediction
    function void check_event(logic kind, logic [tksd_pkg::CODE_W-1:0] code, logic sh,
                              logic ct);
      tksd_pkg::result_t exp_ev;
      if (pending_events.size() == 0) begin
        $error("unexpected key event: kind %0d code %0h shift %0d ctrl %0d",
               kind, code, sh, ct);
        errors++;
        return;
      end
      exp_ev = pending_events.pop_front();
      if (exp_ev.kind !== kind) begin
        $error("event_kind: expected %0d, got %0d", exp_ev.kind, kind);
        errors++;
      end
      if (exp_ev.code !== code) begin
        $error("key_code: expected %0h, got %0h", exp_ev.code, code);
        errors++;
      end
      if (exp_ev.shift !== sh) begin
        $error("shift_flag: expected %0d, got %0d", exp_ev.shift, sh);
        errors++;
      end
      if (exp_ev.ctrl !== ct) begin
        $error("control_flag: expected %0d, got %0d", exp_ev.ctrl, ct);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic [0:0]  in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;

  key_event_scoreboard sb = new();
  tksd_pkg::item_t     keystrokes[$];
  int                  rx_cycle = 0;

  terminal_key_sequence_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels; values read at the edge are the pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_item(in_tdata, in_tuser[0]);
      if (out_tvalid && out_tready)
        sb.check_event(out_tuser[0], out_tdata[tksd_pkg::CODE_W-1:0], out_tuser[1],
                       out_tuser[2]);
    end
  end

  // Receiver: rotating stall patterns plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_cycle   <= 0;
      out_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN) begin
        out_tready <= 1'b0;
      end else begin
        case (rx_cycle[9:8])
          2'd0: out_tready <= 1'b1;
          2'd1: out_tready <= ($urandom_range(0, 1) == 0);
          2'd2: out_tready <= (rx_cycle[2:0] < 3'd3);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic void push_byte(logic [7:0] b);
    keystrokes.push_back({1'b0, b});
  endfunction

  // Idle marker; the byte lanes carry noise that the block must ignore
  function automatic void push_idle();
    keystrokes.push_back({1'b1, 8'($urandom)});
  endfunction

  function automatic logic [7:0] any_digit();
    return tksd_pkg::CH_0 + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed key sequences with random content, some noise and breaks
  function automatic void add_random_sequence();
    int unsigned sel;
    int unsigned n;
    logic [7:0]  tail;
    sel  = $urandom_range(0, 19);
    tail = $urandom_range(0, 1) ? tksd_pkg::CH_TILDE : tksd_pkg::CH_CARET;
    if (sel >= 6 && sel <= 15 || sel >= 18) begin
      push_byte(tksd_pkg::CH_ESC);
      if (sel != 7 && sel != 8) push_byte(tksd_pkg::CH_LBRK);
    end
    case (sel)
      0, 1, 2: push_byte(8'($urandom_range(0, 127)));
      3, 4: begin
        n = $urandom_range(1, 3);
        case (n)
          1: push_byte(tksd_pkg::UTF_LEAD2 | 8'($urandom_range(0, 31)));
          2: push_byte(tksd_pkg::UTF_LEAD3 | 8'($urandom_range(0, 15)));
          default: push_byte(tksd_pkg::UTF_LEAD4 | 8'($urandom_range(0, 7)));
        endcase
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 11) == 0) begin
            push_idle();
            break;
          end
          push_byte($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h80 | 8'($urandom_range(0, 63)));
        end
      end
      5: begin
        push_byte(tksd_pkg::CH_ESC);
        push_idle();
      end
      6: push_byte(CSI_FINALS[8 * $urandom_range(0, 5) +: 8]);
      7: begin
        push_byte(tksd_pkg::CH_O);
        push_byte($urandom_range(0, 4) == 0 ? 8'($urandom)
                                            : tksd_pkg::CH_P + 8'($urandom_range(0, 3)));
      end
      8: begin
        case ($urandom_range(0, 2))
          0: push_byte(tksd_pkg::CH_LB);
          1: push_byte(tksd_pkg::CH_LF);
          default: push_byte(8'($urandom));
        endcase
      end
      9: begin
        push_byte(tksd_pkg::CH_1);
        push_byte(any_digit());
        push_byte(tail);
      end
      10: begin
        push_byte(tksd_pkg::CH_1);
        push_byte(tksd_pkg::CH_SEMI);
        push_byte(tksd_pkg::CH_2);
        case ($urandom_range(0, 2))
          0: push_byte(tksd_pkg::CH_C);
          1: push_byte(tksd_pkg::CH_D);
          default: push_byte(8'($urandom));
        endcase
      end
      11: begin
        push_byte(tksd_pkg::CH_2);
        push_byte(tksd_pkg::CH_TILDE);
      end
      12: begin
        push_byte(tksd_pkg::CH_2);
        push_byte(any_digit());
        push_byte(tail);
      end
      13: begin
        push_byte(tksd_pkg::CH_2);
        push_byte($urandom_range(0, 3) == 0 ? any_digit() : tksd_pkg::CH_0);
        push_byte($urandom_range(0, 3) == 0 ? any_digit()
                                            : tksd_pkg::CH_0 + 8'($urandom_range(0, 1)));
        push_byte($urandom_range(0, 5) == 0 ? 8'($urandom) : tksd_pkg::CH_TILDE);
      end
      14: begin
        push_byte(tksd_pkg::CH_3 + 8'($urandom_range(0, 5)));
        push_byte(tksd_pkg::CH_TILDE);
      end
      15: begin
        push_byte(tksd_pkg::CH_3);
        push_byte(tksd_pkg::CH_0 + 8'($urandom_range(0, 5)));
        push_byte($urandom_range(0, 5) == 0 ? 8'($urandom) : tksd_pkg::CH_TILDE);
      end
      16: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) push_byte(8'($urandom));
      end
      17: push_idle();
      18: begin
        push_byte(8'($urandom));
        push_byte(8'($urandom));
      end
      default: begin
        push_byte(tksd_pkg::CH_1);
        push_byte(8'($urandom));
        push_byte(8'($urandom));
      end
    endcase
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic drive_item(input tksd_pkg::item_t it);
    in_tvalid <= 1'b1;
    in_tdata  <= it.data;
    in_tuser  <= it.idle;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int idx;
    int burst;
    int gap;
    int guard;
    int directed_n;

    // Directed: byte extremes, lone escape, ESC b, ESC ESC dropped, UTF-8 up to the
    // largest 21-bit code, invalid lead, partial UTF-8 cut by idle, CSI 2 7 ~ dropped,
    // bracketed paste start
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(tksd_pkg::CH_ESC);
    push_idle();
    push_byte(tksd_pkg::CH_ESC);
    push_byte(tksd_pkg::CH_LB);
    push_byte(tksd_pkg::CH_ESC);
    push_byte(tksd_pkg::CH_ESC);
    push_byte(8'hC3);
    push_byte(8'hA9);
    push_byte(8'hF7);
    push_byte(8'hBF);
    push_byte(8'hBF);
    push_byte(8'hBF);
    push_byte(8'hFF);
    push_byte(8'hE2);
    push_byte(8'h82);
    push_idle();
    push_byte(tksd_pkg::CH_ESC);
    push_byte(tksd_pkg::CH_LBRK);
    push_byte(tksd_pkg::CH_2);
    push_byte(tksd_pkg::CH_7);
    push_byte(tksd_pkg::CH_TILDE);
    push_byte(tksd_pkg::CH_ESC);
    push_byte(tksd_pkg::CH_LBRK);
    push_byte(tksd_pkg::CH_2);
    push_byte(tksd_pkg::CH_0);
    push_byte(tksd_pkg::CH_0);
    push_byte(tksd_pkg::CH_TILDE);
    directed_n = keystrokes.size();
    while (keystrokes.size() < directed_n + RANDOM_ITEMS) add_random_sequence();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender: bursts of random length, sometimes back to back
    idx = 0;
    while (idx < keystrokes.size()) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && idx < keystrokes.size(); k++) begin
        drive_item(keystrokes[idx]);
        idx++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    // Let the last events drain, then allow a few more cycles for strays
    guard = 0;
    while (sb.pending_events.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_events.size() != 0) begin
      $error("%0d predicted key events never arrived", sb.pending_events.size());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("terminal_key_sequence_decoder test passed");
    end else begin
      $display("terminal_key_sequence_decoder test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("terminal_key_sequence_decoder test failed");
    $finish;
  end

endmodule
